>>> hdl/incdf_pkg.sv
// ----------------------------------------------------------------------------
// incdf_pkg: shared constants and types for the normal quantile pipeline
// Fixed-point formats, rational approximation coefficients and the sideband
// structure that travels with each beat through the pipeline.
// ----------------------------------------------------------------------------
package incdf_pkg;

  // Width of the probability held in the input beat (unsigned Q0.PROB_BITS).
  localparam int PROB_BITS = 32;

  // Fraction bits of the working format and of the logarithm.
  localparam int WFRAC = 28;
  localparam int LFRAC = 30;

  // Exponent of the leading one and the scaled negative logarithm.
  localparam int EXP_W = $clog2(PROB_BITS);
  localparam int U_W   = $clog2(PROB_BITS + 1) + LFRAC;

  // Normalised mantissa in Q1.30.
  localparam int M_W = LFRAC + 1;

  // ln 2 in Q0.28, rounded.
  localparam logic [WFRAC-1:0] K_LN2 = 28'd186065279;

  // t squared, its square root and the square-root recurrence.
  localparam int T2_W     = $clog2(longint'(PROB_BITS) * 2 * 186065279 + 1);
  localparam int RAD_W    = T2_W + WFRAC;
  localparam int SQ_STEPS = (RAD_W + 1) / 2;
  localparam int T_W      = SQ_STEPS;
  localparam int SQ_W     = RAD_W + 1;

  // Rational approximation coefficients in Q.28, rounded from millionths.
  localparam logic [63:0] K_C0 = ((64'd2515517 << WFRAC) + 64'd500000) / 64'd1000000;
  localparam logic [63:0] K_C1 = ((64'd802853 << WFRAC) + 64'd500000) / 64'd1000000;
  localparam logic [63:0] K_C2 = ((64'd10328 << WFRAC) + 64'd500000) / 64'd1000000;
  localparam logic [63:0] K_D1 = ((64'd1432788 << WFRAC) + 64'd500000) / 64'd1000000;
  localparam logic [63:0] K_D2 = ((64'd189269 << WFRAC) + 64'd500000) / 64'd1000000;
  localparam logic [63:0] K_D3 = ((64'd1308 << WFRAC) + 64'd500000) / 64'd1000000;
  localparam logic [63:0] K_ONE = 64'd1 << WFRAC;
  localparam logic [63:0] K_HALF_LSB = 64'd1 << (WFRAC - 1);

  // Numerator and denominator of the rational term, and the quotient.
  localparam int NUM_W     = 34;
  localparam int REM_W     = 64;
  localparam int DIV_STEPS = 30;
  localparam int MAG_W     = 32;

  // Register indexes of the configuration port.
  localparam logic REG_MEAN  = 1'b0;
  localparam logic REG_SIGMA = 1'b1;

  // Sideband carried with every beat.
  typedef struct packed {
    logic mirror;
    logic derr;
  } side_t;

endpackage

>>> hdl/incdf_log2.sv
// ----------------------------------------------------------------------------
// incdf_log2: pipelined negative base-two logarithm
// Finds the leading one, normalises the mantissa and extracts one fraction
// bit per stage by repeated squaring. Returns (PROB_BITS - log2 q) in Q.30.
// ----------------------------------------------------------------------------
module incdf_log2 import incdf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [PROB_BITS-1:0] in_q,
  input  side_t                in_side,
  output logic                 out_valid,
  output logic [U_W-1:0]       out_u,
  output side_t                out_side
);

  // Leading-one stage registers.
  logic                 lv_r;
  logic [PROB_BITS-1:0] lq_r;
  logic [EXP_W-1:0]     le_r;
  side_t                ls_r;
  logic [EXP_W-1:0]     le_nxt;

  // Squaring stage registers, index 0 is the normalised mantissa.
  logic             sv_r [0:LFRAC];
  logic [M_W-1:0]   sm_r [0:LFRAC];
  logic [LFRAC-1:0] sf_r [0:LFRAC];
  logic [EXP_W-1:0] se_r [0:LFRAC];
  side_t            ss_r [0:LFRAC];

  logic [PROB_BITS+LFRAC-1:0] norm_wide;

  // Output stage registers.
  logic           uv_r;
  logic [U_W-1:0] u_r;
  side_t          us_r;

  // Position of the leading one.
  always_comb begin
    le_nxt = '0;
    for (int i = 0; i < PROB_BITS; i++) begin
      if (in_q[i]) begin
        le_nxt = EXP_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= 1'b0;
    end else if (en) begin
      lv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lq_r <= in_q;
      le_r <= le_nxt;
      ls_r <= in_side;
    end
  end

  // Normalise to Q1.30, dropping bits below the fraction.
  assign norm_wide = {lq_r, {LFRAC{1'b0}}} >> le_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= lv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm_r[0] <= norm_wide[M_W-1:0];
      sf_r[0] <= '0;
      se_r[0] <= le_r;
      ss_r[0] <= ls_r;
    end
  end

  // One fraction bit per stage: square, and halve when the square reaches two.
  for (genvar k = 0; k < LFRAC; k++) begin : g_sq
    logic [2*M_W-1:0] sq;
    logic [M_W:0]     sq_top;
    logic [M_W-1:0]   m_nxt;
    logic [LFRAC-1:0] f_nxt;

    assign sq     = (2*M_W)'(sm_r[k]) * (2*M_W)'(sm_r[k]);
    assign sq_top = sq[LFRAC+M_W:LFRAC];

    always_comb begin
      f_nxt = sf_r[k];
      if (sq_top[M_W]) begin
        m_nxt = sq_top[M_W:1];
        f_nxt[LFRAC-1-k] = 1'b1;
      end else begin
        m_nxt = sq_top[M_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else if (en) begin
        sv_r[k+1] <= sv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sm_r[k+1] <= m_nxt;
        sf_r[k+1] <= f_nxt;
        se_r[k+1] <= se_r[k];
        ss_r[k+1] <= ss_r[k];
      end
    end
  end

  // Combine exponent and fraction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uv_r <= 1'b0;
    end else if (en) begin
      uv_r <= sv_r[LFRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r  <= (U_W'(PROB_BITS) - U_W'(se_r[LFRAC])) * (U_W'(1) << LFRAC)
              - U_W'(sf_r[LFRAC]);
      us_r <= ss_r[LFRAC];
    end
  end

  assign out_valid = uv_r;
  assign out_u     = u_r;
  assign out_side  = us_r;

endmodule

>>> hdl/inverse_normal_cdf_approx.sv
// ----------------------------------------------------------------------------
// inverse_normal_cdf_approx: normal quantile, rational approximation
// Throughput: one beat per cycle; the whole pipeline holds while an output
// beat waits, and a bubble in the output register lets it move on again.
// Reset clears all valid bits and loads mean 0 and sigma 1.0.
// Stages: select q, logarithm (33), t squared, square root (31),
// polynomials (3), division (30), difference, product, output.
// ----------------------------------------------------------------------------
module inverse_normal_cdf_approx import incdf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream. tdata: probability [31:0].
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // Output stream. tdata: quantile [39:0]. tuser: domain_error [0].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic [0:0]  out_tuser,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic adv;

  // Configuration registers.
  logic [31:0] mean_r;
  logic [31:0] sigma_r;

  // Input stage.
  logic                 iv_r;
  logic [PROB_BITS-1:0] iq_r;
  side_t                is_r;
  logic [PROB_BITS-1:0] p_in;
  logic                 mirror_in;

  // Logarithm output.
  logic           lg_valid;
  logic [U_W-1:0] lg_u;
  side_t          lg_side;

  // Square-root stages, index 0 is the t squared stage.
  logic             qv_r  [0:SQ_STEPS];
  logic [SQ_W-1:0]  qrad_r[0:SQ_STEPS];
  logic [SQ_W-1:0]  qrt_r [1:SQ_STEPS];
  logic [T2_W-1:0]  qt2_r [0:SQ_STEPS];
  side_t            qs_r  [0:SQ_STEPS];
  logic [63:0]      t2_prod;

  // Polynomial stages.
  logic            p1v_r, p2v_r;
  logic [T_W-1:0]  p1t_r, p2t_r;
  side_t           p1s_r, p2s_r;
  logic [63:0]     c1t_r, c2t2_r, d1t_r, d2t2_r, d3t2_r;
  logic [NUM_W-1:0] num_r, dena_r, d3t3_r;
  logic [T_W-1:0]  t_sq;
  logic [T2_W-1:0] t2_sq;
  logic [63:0]     c1t_nxt, c2t2_nxt, d1t_nxt, d2t2_nxt, d3t2_nxt, d3t3_nxt;
  logic [NUM_W-1:0] den_nxt;

  // Division stages, index 0 holds the rounded dividend.
  logic                 dv_r  [0:DIV_STEPS];
  logic [REM_W-1:0]     drem_r[0:DIV_STEPS];
  logic [NUM_W-1:0]     dden_r[0:DIV_STEPS];
  logic [DIV_STEPS-1:0] dq_r  [1:DIV_STEPS];
  logic [T_W-1:0]       dt_r  [0:DIV_STEPS];
  side_t                ds_r  [0:DIV_STEPS];

  // Difference, product and output stages.
  logic             zv_r, mv_r, ov_r;
  logic [MAG_W-1:0] mag_r;
  logic             zneg_r, mneg_r;
  logic             zerr_r, merr_r;
  logic [63:0]      prod_r;
  logic signed [32:0] z_diff;
  logic [32:0]      z_abs;
  logic [63:0]      prod_rnd;
  logic signed [39:0] mean_ext, res_nxt;
  logic [39:0]      q_r;
  logic             err_r;

  // The pipeline moves as one whenever the output register can take a beat.
  assign adv       = !ov_r || out_tready;
  assign in_tready = adv;

  // Configuration writes and reads.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r  <= 32'd0;
      sigma_r <= 32'd65536;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (cfg_paddr[2])
        REG_MEAN:  mean_r  <= cfg_pwdata;
        REG_SIGMA: sigma_r <= cfg_pwdata;
        default:   mean_r  <= mean_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_MEAN:  cfg_prdata = mean_r;
      REG_SIGMA: cfg_prdata = sigma_r;
      default:   cfg_prdata = '0;
    endcase
  end

  // Select q = p or 1 - p and flag a zero probability.
  assign p_in      = in_tdata[PROB_BITS-1:0];
  assign mirror_in = p_in > (PROB_BITS'(1) << (PROB_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (adv) begin
      iv_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      iq_r        <= mirror_in ? (PROB_BITS'(0) - p_in) : p_in;
      is_r.mirror <= mirror_in;
      is_r.derr   <= (p_in == '0);
    end
  end

  incdf_log2 u_log2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (iv_r),
    .in_q      (iq_r),
    .in_side   (is_r),
    .out_valid (lg_valid),
    .out_u     (lg_u),
    .out_side  (lg_side)
  );

  // t squared = 2 ln2 times the scaled logarithm, in Q.28.
  assign t2_prod = 64'(lg_u) * 64'(K_LN2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r[0] <= 1'b0;
    end else if (adv) begin
      qv_r[0] <= lg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qt2_r[0]  <= t2_prod[LFRAC-1+T2_W-1:LFRAC-1];
      qrad_r[0] <= SQ_W'(t2_prod[LFRAC-1+T2_W-1:LFRAC-1]) << WFRAC;
      qs_r[0]   <= lg_side;
    end
  end

  // Square root, one result bit per stage.
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [SQ_W-1:0] r_in;
    logic [SQ_W-1:0] rb;
    logic [SQ_W-1:0] v_nxt;
    logic [SQ_W-1:0] r_nxt;

    if (k == 0) begin : g_first
      assign r_in = '0;
    end else begin : g_rest
      assign r_in = qrt_r[k];
    end

    assign rb = r_in + BIT;

    always_comb begin
      if (qrad_r[k] >= rb) begin
        v_nxt = qrad_r[k] - rb;
        r_nxt = (r_in >> 1) + BIT;
      end else begin
        v_nxt = qrad_r[k];
        r_nxt = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qv_r[k+1] <= 1'b0;
      end else if (adv) begin
        qv_r[k+1] <= qv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        qrad_r[k+1] <= v_nxt;
        qrt_r[k+1]  <= r_nxt;
        qt2_r[k+1]  <= qt2_r[k];
        qs_r[k+1]   <= qs_r[k];
      end
    end
  end

  // First polynomial stage: the products with t and t squared.
  assign t_sq  = qrt_r[SQ_STEPS][T_W-1:0];
  assign t2_sq = qt2_r[SQ_STEPS];

  assign c1t_nxt  = (K_C1 * 64'(t_sq) + K_HALF_LSB) >> WFRAC;
  assign c2t2_nxt = (K_C2 * 64'(t2_sq) + K_HALF_LSB) >> WFRAC;
  assign d1t_nxt  = (K_D1 * 64'(t_sq) + K_HALF_LSB) >> WFRAC;
  assign d2t2_nxt = (K_D2 * 64'(t2_sq) + K_HALF_LSB) >> WFRAC;
  assign d3t2_nxt = (K_D3 * 64'(t2_sq) + K_HALF_LSB) >> WFRAC;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1v_r <= 1'b0;
      p2v_r <= 1'b0;
    end else if (adv) begin
      p1v_r <= qv_r[SQ_STEPS];
      p2v_r <= p1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1t_r  <= t_sq;
      p1s_r  <= qs_r[SQ_STEPS];
      c1t_r  <= c1t_nxt;
      c2t2_r <= c2t2_nxt;
      d1t_r  <= d1t_nxt;
      d2t2_r <= d2t2_nxt;
      d3t2_r <= d3t2_nxt;
    end
  end

  // Second polynomial stage: the cubic term and the partial sums.
  // d3 t squared stays below 2^25, so its low 32 bits carry the whole value.
  assign d3t3_nxt = (64'(d3t2_r[31:0]) * 64'(p1t_r) + K_HALF_LSB) >> WFRAC;

  always_ff @(posedge clk) begin
    if (adv) begin
      p2t_r  <= p1t_r;
      p2s_r  <= p1s_r;
      num_r  <= NUM_W'(K_C0 + c1t_r + c2t2_r);
      dena_r <= NUM_W'(K_ONE + d1t_r + d2t2_r);
      d3t3_r <= d3t3_nxt[NUM_W-1:0];
    end
  end

  // Third polynomial stage: full denominator and the dividend rounded by half.
  assign den_nxt = dena_r + d3t3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= p2v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drem_r[0] <= (REM_W'(num_r) << WFRAC) + REM_W'(den_nxt >> 1);
      dden_r[0] <= den_nxt;
      dt_r[0]   <= p2t_r;
      ds_r[0]   <= p2s_r;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [DIV_STEPS-1:0] q_in;
    logic [REM_W-1:0]     dsh;
    logic                 take;

    if (k == 0) begin : g_first
      assign q_in = '0;
    end else begin : g_rest
      assign q_in = dq_r[k];
    end

    assign dsh  = REM_W'(dden_r[k]) << (DIV_STEPS - 1 - k);
    assign take = drem_r[k] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        drem_r[k+1] <= take ? (drem_r[k] - dsh) : drem_r[k];
        dq_r[k+1]   <= {q_in[DIV_STEPS-2:0], take};
        dden_r[k+1] <= dden_r[k];
        dt_r[k+1]   <= dt_r[k];
        ds_r[k+1]   <= ds_r[k];
      end
    end
  end

  // z = quotient - t, split into magnitude and sign.
  assign z_diff = $signed({3'b000, dq_r[DIV_STEPS]}) - $signed({2'b00, dt_r[DIV_STEPS]});
  assign z_abs  = z_diff[32] ? 33'(-z_diff) : 33'(z_diff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zv_r <= 1'b0;
      mv_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      zv_r <= dv_r[DIV_STEPS];
      mv_r <= zv_r;
      ov_r <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r  <= z_abs[MAG_W-1:0];
      zneg_r <= z_diff[32] ^ ds_r[DIV_STEPS].mirror;
      zerr_r <= ds_r[DIV_STEPS].derr;
    end
  end

  // Scale the magnitude by sigma.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= 64'(mag_r) * 64'(sigma_r);
      mneg_r <= zneg_r;
      merr_r <= zerr_r;
    end
  end

  // Round to Q.16, apply the sign and add the mean.
  assign prod_rnd = (prod_r + K_HALF_LSB) >> WFRAC;
  assign mean_ext = 40'(signed'(mean_r));
  assign res_nxt  = mneg_r ? (mean_ext - $signed({3'b000, prod_rnd[36:0]}))
                           : (mean_ext + $signed({3'b000, prod_rnd[36:0]}));

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r   <= merr_r ? 40'd0 : 40'(res_nxt);
      err_r <= merr_r;
    end
  end

  assign out_tvalid   = ov_r;
  assign out_tdata    = q_r;
  assign out_tuser[0] = err_r;

endmodule
